// ===== design/cdeq_pkg.sv =====
package cdeq_pkg;

    // word width of one deque entry
    localparam int DATA_W = 32;

    // default number of entries
    localparam int DEPTH_DEF = 8;

    // request kinds
    typedef enum logic [1:0] {
        KIND_PUSH_FRONT = 2'd0,
        KIND_PUSH_REAR  = 2'd1,
        KIND_POP_FRONT  = 2'd2,
        KIND_POP_REAR   = 2'd3
    } t_kind;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } t_status;

    // per-cycle command broadcast to every cell, already qualified
    typedef struct packed {
        logic push_front;
        logic push_rear;
        logic pop_front;
        logic pop_rear;
    } t_cell_ctrl;

endpackage

// ===== design/cdeq_cell.sv =====
module cdeq_cell
    import cdeq_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cell_ctrl               i_ctrl,
    input  logic signed [DATA_W-1:0] i_push_data,
    input  logic signed [DATA_W-1:0] i_prev_data,
    input  logic                     i_prev_valid,
    input  logic signed [DATA_W-1:0] i_next_data,
    input  logic                     i_next_valid,
    output logic signed [DATA_W-1:0] o_data,
    output logic                     o_valid,
    output logic                     o_last
);

    logic signed [DATA_W-1:0] r_data;
    logic signed [DATA_W-1:0] n_data;
    logic                     r_valid;
    logic                     n_valid;

    // next entry: shift toward the rear, fill the first free slot,
    // shift toward the front, or drop the rear-most entry
    always_comb begin
        n_data  = r_data;
        n_valid = r_valid;
        if (i_ctrl.push_front) begin
            n_data  = i_prev_data;
            n_valid = i_prev_valid;
        end else if (i_ctrl.push_rear) begin
            if (!r_valid && i_prev_valid) begin
                n_data  = i_push_data;
                n_valid = 1'b1;
            end
        end else if (i_ctrl.pop_front) begin
            n_data  = i_next_data;
            n_valid = i_next_valid;
        end else if (i_ctrl.pop_rear) begin
            if (r_valid && !i_next_valid) begin
                n_valid = 1'b0;
            end
        end
    end

    // occupancy bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // entry word
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data  = r_data;
    assign o_valid = r_valid;
    assign o_last  = r_valid & ~i_next_valid;

endmodule

// ===== design/circular_double_ended_queue_unit.sv =====
// Double-ended queue of DEPTH signed 32-bit words.
// Input channel: i_valid/o_stall carry one request (i_kind, i_data):
//   push front, push rear, pop front or pop rear.
// Output channel: o_valid/i_stall carry one result per request:
//   o_popped_value (zero unless a pop succeeded), o_status (done, full,
//   empty) and the now-empty / now-full flags after the request.
// Storage is a row of DEPTH identical cells; the front entry always sits in
// cell 0, a front push or pop shifts every cell by one place, and a rear push
// or pop touches only the cell at the occupancy boundary.
// The result of an accepted transaction is registered and appears in the
// next cycle; a new request is taken every cycle while the result register
// drains, so the throughput is 1 transaction per cycle.
// When the receiver stalls, the result is held and o_stall rises so no new
// request is taken until the result leaves.
// Reset empties the deque (all occupancy bits cleared) and drops any
// pending result; entry words themselves are not cleared.
module circular_double_ended_queue_unit
    import cdeq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [1:0]               i_kind,
    input  logic signed [DATA_W-1:0] i_data,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [DATA_W-1:0] o_popped_value,
    output logic [1:0]               o_status,
    output logic                     o_now_empty,
    output logic                     o_now_full
);

    logic signed [DATA_W-1:0] c_data  [DEPTH];
    logic                     c_valid [DEPTH];
    logic                     c_last  [DEPTH];

    t_kind                    w_kind;
    t_cell_ctrl               w_ctrl;
    logic                     w_accept;
    logic                     w_is_push;
    logic                     w_cur_empty;
    logic                     w_cur_full;
    logic                     w_single;
    logic                     w_almost_full;
    logic signed [DATA_W-1:0] w_rear_data;

    logic                     r_out_valid;
    logic                     n_out_valid;
    logic signed [DATA_W-1:0] r_popped;
    logic signed [DATA_W-1:0] n_popped;
    t_status                  r_status;
    t_status                  n_status;
    logic                     r_now_empty;
    logic                     n_now_empty;
    logic                     r_now_full;
    logic                     n_now_full;

    // handshake
    assign o_stall   = r_out_valid & i_stall;
    assign w_accept  = i_valid & ~o_stall;
    assign w_kind    = t_kind'(i_kind);
    assign w_is_push = (w_kind == KIND_PUSH_FRONT) || (w_kind == KIND_PUSH_REAR);

    // occupancy summary from the cell row
    assign w_cur_empty   = ~c_valid[0];
    assign w_cur_full    = c_valid[DEPTH-1];
    assign w_single      = c_valid[0] & ~c_valid[1];
    assign w_almost_full = c_valid[DEPTH-2] & ~c_valid[DEPTH-1];

    // qualified command to the cells
    always_comb begin
        w_ctrl            = '0;
        w_ctrl.push_front = w_accept && (w_kind == KIND_PUSH_FRONT) && !w_cur_full;
        w_ctrl.push_rear  = w_accept && (w_kind == KIND_PUSH_REAR) && !w_cur_full;
        w_ctrl.pop_front  = w_accept && (w_kind == KIND_POP_FRONT) && !w_cur_empty;
        w_ctrl.pop_rear   = w_accept && (w_kind == KIND_POP_REAR) && !w_cur_empty;
    end

    // cell row, each linked to its neighbors
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [DATA_W-1:0] w_prev_data;
        logic                     w_prev_valid;
        logic signed [DATA_W-1:0] w_next_data;
        logic                     w_next_valid;

        if (g == 0) begin : g_head
            assign w_prev_data  = i_data;
            assign w_prev_valid = 1'b1;
        end else begin : g_body
            assign w_prev_data  = c_data[g-1];
            assign w_prev_valid = c_valid[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_next_data  = '0;
            assign w_next_valid = 1'b0;
        end else begin : g_link
            assign w_next_data  = c_data[g+1];
            assign w_next_valid = c_valid[g+1];
        end

        cdeq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_push_data  (i_data),
            .i_prev_data  (w_prev_data),
            .i_prev_valid (w_prev_valid),
            .i_next_data  (w_next_data),
            .i_next_valid (w_next_valid),
            .o_data       (c_data[g]),
            .o_valid      (c_valid[g]),
            .o_last       (c_last[g])
        );
    end

    // rear word: only the boundary cell contributes
    always_comb begin
        w_rear_data = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_rear_data = w_rear_data | (c_last[k] ? c_data[k] : '0);
        end
    end

    // result of the request being accepted
    always_comb begin
        n_popped    = '0;
        n_status    = STATUS_DONE;
        n_now_empty = w_is_push ? 1'b0 : (w_cur_empty | w_single);
        n_now_full  = w_is_push ? (w_cur_full | w_almost_full) : 1'b0;
        case (w_kind)
            KIND_PUSH_FRONT, KIND_PUSH_REAR: begin
                if (w_cur_full) begin
                    n_status = STATUS_FULL;
                end
            end
            KIND_POP_FRONT: begin
                if (w_cur_empty) begin
                    n_status = STATUS_EMPTY;
                end else begin
                    n_popped = c_data[0];
                end
            end
            KIND_POP_REAR: begin
                if (w_cur_empty) begin
                    n_status = STATUS_EMPTY;
                end else begin
                    n_popped = w_rear_data;
                end
            end
            default: begin
                n_status = STATUS_DONE;
            end
        endcase
    end

    // output valid
    assign n_out_valid = w_accept | (r_out_valid & i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_popped    <= n_popped;
            r_status    <= n_status;
            r_now_empty <= n_now_empty;
            r_now_full  <= n_now_full;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_popped_value = r_popped;
    assign o_status       = r_status;
    assign o_now_empty    = r_now_empty;
    assign o_now_full     = r_now_full;

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cdeq_pkg::*;

    localparam int DEPTH          = DEPTH_DEF;
    localparam int RANDOM_ITEMS   = 2000;
    localparam int SHOWN_ERRORS   = 10;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SCRIPT_LEN     = 25;

    // one result transaction as the block reports it
    typedef struct packed {
        logic signed [DATA_W-1:0] popped;
        t_status                  status;
        logic                     now_empty;
        logic                     now_full;
    } t_deque_result;

    // one directed request, with a typed-in result where it is obvious
    typedef struct packed {
        t_kind                    kind;
        logic signed [DATA_W-1:0] word;
        logic                     fixed;
        t_deque_result            want;
    } t_script_row;

    localparam t_deque_result UNCHECKED = '{32'sh0, STATUS_DONE, 1'b0, 1'b0};

    // directed requests: empty pops, single-entry pops, fill from both ends, full pushes, drain
    localparam t_script_row DIRECTED_ROWS [SCRIPT_LEN] = '{
        '{KIND_POP_FRONT,  32'sh0,        1'b1, '{32'sh0, STATUS_EMPTY, 1'b1, 1'b0}},
        '{KIND_POP_REAR,   32'shffffffff, 1'b1, '{32'sh0, STATUS_EMPTY, 1'b1, 1'b0}},
        '{KIND_PUSH_FRONT, 32'sh80000000, 1'b0, UNCHECKED},
        '{KIND_POP_FRONT,  32'sh0,        1'b1, '{32'sh80000000, STATUS_DONE, 1'b1, 1'b0}},
        '{KIND_PUSH_REAR,  32'sh7fffffff, 1'b0, UNCHECKED},
        '{KIND_POP_REAR,   32'sh0,        1'b1, '{32'sh7fffffff, STATUS_DONE, 1'b1, 1'b0}},
        '{KIND_PUSH_REAR,  32'shffffffff, 1'b0, UNCHECKED},
        '{KIND_PUSH_FRONT, 32'sh00000000, 1'b0, UNCHECKED},
        '{KIND_PUSH_FRONT, 32'sh55555555, 1'b0, UNCHECKED},
        '{KIND_PUSH_REAR,  32'shaaaaaaaa, 1'b0, UNCHECKED},
        '{KIND_PUSH_REAR,  32'sh12345678, 1'b0, UNCHECKED},
        '{KIND_PUSH_FRONT, 32'sh80000001, 1'b0, UNCHECKED},
        '{KIND_PUSH_REAR,  32'sh7ffffffe, 1'b0, UNCHECKED},
        '{KIND_PUSH_REAR,  32'shdeadbeef, 1'b0, UNCHECKED},
        '{KIND_PUSH_FRONT, 32'sh00000001, 1'b1, '{32'sh0, STATUS_FULL, 1'b0, 1'b1}},
        '{KIND_PUSH_REAR,  32'sh00000002, 1'b1, '{32'sh0, STATUS_FULL, 1'b0, 1'b1}},
        '{KIND_POP_REAR,   32'sh0,        1'b0, UNCHECKED},
        '{KIND_POP_FRONT,  32'sh0,        1'b0, UNCHECKED},
        '{KIND_POP_REAR,   32'sh0,        1'b0, UNCHECKED},
        '{KIND_POP_FRONT,  32'sh0,        1'b0, UNCHECKED},
        '{KIND_POP_REAR,   32'sh0,        1'b0, UNCHECKED},
        '{KIND_POP_FRONT,  32'sh0,        1'b0, UNCHECKED},
        '{KIND_POP_REAR,   32'sh0,        1'b0, UNCHECKED},
        '{KIND_POP_FRONT,  32'sh0,        1'b0, UNCHECKED},
        '{KIND_POP_REAR,   32'sh0,        1'b1, '{32'sh0, STATUS_EMPTY, 1'b1, 1'b0}}
    };

    logic                     i_clk   = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     i_stall = 1'b0;
    t_kind                    req_kind = KIND_PUSH_FRONT;
    logic signed [DATA_W-1:0] req_data = '0;
    logic                     o_stall;
    logic                     o_valid;
    logic signed [DATA_W-1:0] o_popped_value;
    logic [1:0]               o_status;
    logic                     o_now_empty;
    logic                     o_now_full;

    // typed-in result riding along with the current request
    logic                     row_fixed = 1'b0;
    t_deque_result            row_want  = UNCHECKED;

    // predictor state: words from front to rear
    logic signed [DATA_W-1:0] deque_words [$];
    t_deque_result            pending_results [$];

    bit calm = 1'b0;
    int error_count    = 0;
    int idle_cycles    = 0;
    int requests_taken = 0;
    int results_seen   = 0;
    int full_rejects   = 0;
    int empty_rejects  = 0;
    int full_reached   = 0;

    circular_double_ended_queue_unit #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_kind         (req_kind),
        .i_data         (req_data),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_popped_value (o_popped_value),
        .o_status       (o_status),
        .o_now_empty    (o_now_empty),
        .o_now_full     (o_now_full)
    );

    // 4 ns clock
    always #2 i_clk = ~i_clk;

    // deque behavior: apply one request, return the result it produces
    function automatic t_deque_result apply_request(t_kind kind,
                                                    logic signed [DATA_W-1:0] word);
        t_deque_result res;
        res = UNCHECKED;
        case (kind)
            KIND_PUSH_FRONT, KIND_PUSH_REAR: begin
                if (deque_words.size() == DEPTH) begin
                    res.status = STATUS_FULL;
                end else if (kind == KIND_PUSH_FRONT) begin
                    deque_words.push_front(word);
                end else begin
                    deque_words.push_back(word);
                end
            end
            default: begin
                if (deque_words.size() == 0) begin
                    res.status = STATUS_EMPTY;
                end else if (kind == KIND_POP_FRONT) begin
                    res.popped = deque_words.pop_front();
                end else begin
                    res.popped = deque_words.pop_back();
                end
            end
        endcase
        res.now_empty = (deque_words.size() == 0);
        res.now_full  = (deque_words.size() == DEPTH);
        return res;
    endfunction

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= SHOWN_ERRORS) begin
            $display("ERROR @%0t: %s", $realtime, msg);
        end
    endtask

    // result checking, request prediction and watchdog, all on the rising edge
    always @(posedge i_clk) begin
        t_deque_result got;
        t_deque_result want;
        bit moved;
        moved = 1'b0;
        if (i_rst_n) begin
            // result transaction
            if (o_valid && !i_stall) begin
                moved = 1'b1;
                results_seen++;
                got.popped    = o_popped_value;
                got.status    = t_status'(o_status);
                got.now_empty = o_now_empty;
                got.now_full  = o_now_full;
                if (pending_results.size() == 0) begin
                    report_error($sformatf("result with nothing pending: popped=%h status=%0d",
                                           got.popped, got.status));
                end else begin
                    want = pending_results.pop_front();
                    if (got.popped !== want.popped || got.status !== want.status ||
                        got.now_empty !== want.now_empty || got.now_full !== want.now_full) begin
                        report_error($sformatf(
                            {"mismatch: popped %h/%h status %0d/%0d ",
                             "empty %b/%b full %b/%b (exp/got)"},
                            want.popped, got.popped, want.status, got.status,
                            want.now_empty, got.now_empty, want.now_full, got.now_full));
                    end
                end
            end
            // request transaction
            if (i_valid && !o_stall) begin
                moved = 1'b1;
                requests_taken++;
                want = apply_request(req_kind, req_data);
                if (want.status == STATUS_FULL) full_rejects++;
                if (want.status == STATUS_EMPTY) empty_rejects++;
                if (want.now_full) full_reached++;
                if (row_fixed) want = row_want;
                pending_results.push_back(want);
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver: random stall before each result, none while calm
    initial begin
        int stall_left;
        @(posedge i_rst_n);
        forever begin
            stall_left = calm ? 0 : $urandom_range(0, 3);
            while (stall_left > 0) begin
                @(negedge i_clk);
                i_stall <= 1'b1;
                stall_left--;
            end
            @(negedge i_clk);
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    // one request transaction, after a random gap, none while calm
    task automatic send_request(input t_kind kind, input logic signed [DATA_W-1:0] word,
                                input logic fixed, input t_deque_result want);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 3);
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid   <= 1'b1;
        req_kind  <= kind;
        req_data  <= word;
        row_fixed <= fixed;
        row_want  <= want;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // hold requests until every pending result has come back
    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'sh80000000;
            1:       return 32'sh7fffffff;
            2:       return -32'sd1;
            3:       return 32'sh0;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int push_pct;
        t_kind kind;
        push_pct = 50;

        // reset
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        for (int r = 0; r < SCRIPT_LEN; r++) begin
            send_request(DIRECTED_ROWS[r].kind, DIRECTED_ROWS[r].word,
                         DIRECTED_ROWS[r].fixed, DIRECTED_ROWS[r].want);
        end

        // random part, push bias shifts so the deque swings between empty and full
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0) begin
                case ($urandom_range(0, 2))
                    0:       push_pct = 15;
                    1:       push_pct = 50;
                    default: push_pct = 85;
                endcase
            end
            calm = ((n / 200) % 4) == 3;
            if (n == 700 || n == 1400) wait_drained();
            if ($urandom_range(0, 99) < push_pct) begin
                kind = $urandom_range(0, 1) ? KIND_PUSH_REAR : KIND_PUSH_FRONT;
            end else begin
                kind = $urandom_range(0, 1) ? KIND_POP_REAR : KIND_POP_FRONT;
            end
            send_request(kind, pick_word(), 1'b0, UNCHECKED);
        end

        // drain and let any stray result show up
        wait_drained();
        repeat (8) @(posedge i_clk);

        if (pending_results.size() != 0) begin
            report_error($sformatf("%0d results never arrived", pending_results.size()));
        end
        if (error_count > SHOWN_ERRORS) begin
            $display("%0d further errors not shown", error_count - SHOWN_ERRORS);
        end
        $display("covered %0d requests and %0d results; %0d pushes refused full, %0d %s",
                 requests_taken, results_seen, full_rejects, empty_rejects,
                 "pops refused empty");
        $display("deque filled to depth %0d on %0d requests; %0d errors", DEPTH, full_reached,
                 error_count);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== circular_double_ended_queue_unit.f =====
design/cdeq_pkg.sv
design/cdeq_cell.sv
design/circular_double_ended_queue_unit.sv
tb/tb_top.sv
